@@ hw/rtl/bmsph_pkg.sv @@
package bmsph_pkg;

    localparam int unsigned BarCountDef  = 24;
    localparam int unsigned FullScaleDef = 100;

    localparam int unsigned LevelW   = 16;
    localparam int unsigned ValueW   = 8;
    localparam int unsigned BarsW    = 7;
    localparam int unsigned SlotW    = 6;
    localparam int unsigned GainW    = 8;
    localparam int unsigned CountW   = 8;
    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned CfgDataW = 8;

    // Register indexes of the configuration port.
    localparam logic [CfgIdxW-1:0] CFG_RISE_GAIN   = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_FALL_GAIN   = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_HOLD_TICKS  = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_DECAY_TICKS = 2'd3;

    localparam logic [CfgDataW-1:0] RiseGainReset   = 8'd77;
    localparam logic [CfgDataW-1:0] FallGainReset   = 8'd13;
    localparam logic [CfgDataW-1:0] HoldTicksReset  = 8'd90;
    localparam logic [CfgDataW-1:0] DecayTicksReset = 8'd18;

    // Bar scaling: value * BAR_COUNT / FULL_SCALE as one multiply by a
    // scaled reciprocal. The product value * BAR_COUNT stays below 2^14 and
    // FULL_SCALE below 2^8, so a 22-bit shift makes the quotient exact.
    localparam int unsigned BarsShift = 22;
    localparam int unsigned BarsMulW  = 29;
    localparam int unsigned BarsProdW = ValueW + BarsMulW;
    localparam int unsigned BarsQuotW = BarsProdW - BarsShift;

    typedef struct packed {
        logic [ValueW-1:0] value;
        logic              value_changed;
        logic              near_goal;
    } t_level;

    typedef struct packed {
        logic [BarsW-1:0]  lit_bars;
        logic [BarsW-1:0]  peak_bars;
        logic              peak_shown;
        logic [SlotW-1:0]  marker_slot;
        logic [ValueW-1:0] shown_value;
        logic              redraw;
        logic              more_ticks;
    } t_result;

endpackage

@@ hw/rtl/bmsph_smooth.sv @@
module bmsph_smooth
    import bmsph_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic              i_opcode,
    input  logic [ValueW-1:0] i_new_target,
    input  logic [GainW-1:0]  i_rise_gain,
    input  logic [GainW-1:0]  i_fall_gain,
    output t_level            o_level
);

    logic [LevelW-1:0]       r_shown;
    logic [LevelW-1:0]       n_shown;
    logic [ValueW-1:0]       r_target;
    logic [ValueW-1:0]       n_target;
    t_level                  r_level;
    t_level                  n_level;

    logic [LevelW-1:0]       goal;
    logic [LevelW-1:0]       mag;
    logic [LevelW-1:0]       step;
    logic                    up;
    logic                    near_goal;
    logic [GainW-1:0]        gain;
    logic [LevelW+GainW-1:0] prod;
    logic [ValueW-1:0]       old_value;
    logic [ValueW-1:0]       new_value;

    // Round Q8.8 to the nearest whole unit, saturating at the top.
    function automatic logic [ValueW-1:0] f_round(input logic [LevelW-1:0] q);
        logic [LevelW:0] s;
        begin
            s = {1'b0, q} + (LevelW+1)'(128);
            f_round = s[LevelW] ? {ValueW{1'b1}} : s[LevelW-1:8];
        end
    endfunction

    always_comb begin
        n_target  = i_opcode ? r_target : i_new_target;
        goal      = {n_target, 8'd0};
        up        = goal > r_shown;
        mag       = up ? goal - r_shown : r_shown - goal;
        near_goal = mag < LevelW'(128);
        gain      = up ? i_rise_gain : i_fall_gain;
        prod      = (LevelW+GainW)'(mag) * (LevelW+GainW)'(gain)
                  + (LevelW+GainW)'(128);

        // Rounded step, at least one LSB and never past the target.
        step = prod[LevelW+GainW-1:GainW];
        if (step == '0) begin
            step = LevelW'(1);
        end
        if (step > mag) begin
            step = mag;
        end

        if (near_goal) begin
            n_shown = goal;
        end else if (up) begin
            n_shown = r_shown + step;
        end else begin
            n_shown = r_shown - step;
        end

        old_value             = f_round(r_shown);
        new_value             = f_round(n_shown);
        n_level.value         = new_value;
        n_level.value_changed = old_value != new_value;
        n_level.near_goal     = near_goal;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shown  <= '0;
            r_target <= '0;
        end else if (i_load) begin
            r_shown  <= n_shown;
            r_target <= n_target;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_level <= n_level;
        end
    end

    assign o_level = r_level;

endmodule

@@ hw/rtl/bmsph_peak.sv @@
module bmsph_peak
    import bmsph_pkg::*;
#(
    parameter int unsigned BAR_COUNT = BarCountDef
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  t_level            i_level,
    input  logic [BarsW-1:0]  i_bars,
    input  logic [CountW-1:0] i_hold_ticks,
    input  logic [CountW-1:0] i_decay_ticks,
    output t_result           o_result
);

    localparam logic [BarsW-1:0] LastSlot = BarsW'(BAR_COUNT - 1);

    logic [BarsW-1:0]  r_peak;
    logic [BarsW-1:0]  n_peak;
    logic [CountW-1:0] r_hold;
    logic [CountW-1:0] n_hold;
    logic [CountW-1:0] r_decay;
    logic [CountW-1:0] n_decay;
    logic [CountW-1:0] decay_inc;
    logic              peak_moved;
    logic              shown;
    logic [BarsW-1:0]  slot;
    t_result           r_result;
    t_result           n_result;

    always_comb begin
        n_peak     = r_peak;
        n_hold     = r_hold;
        n_decay    = r_decay;
        peak_moved = 1'b0;
        decay_inc  = r_decay + CountW'(1);

        priority if (i_bars > r_peak) begin
            n_peak     = i_bars;
            n_hold     = '0;
            n_decay    = '0;
            peak_moved = 1'b1;
        end else if (r_peak > i_bars) begin
            // Hold first, then drop one bar each time the decay count is reached.
            if (r_hold < i_hold_ticks) begin
                n_hold = r_hold + CountW'(1);
            end else if (decay_inc >= i_decay_ticks) begin
                n_peak     = r_peak - BarsW'(1);
                n_decay    = '0;
                peak_moved = 1'b1;
            end else begin
                n_decay = decay_inc;
            end
        end

        shown = n_peak > i_bars;
        if (!shown) begin
            slot = '0;
        end else if (n_peak > i_bars + BarsW'(1)) begin
            slot = n_peak - BarsW'(1);
        end else begin
            slot = i_bars;
        end
        if (slot > LastSlot) begin
            slot = LastSlot;
        end

        n_result.lit_bars    = i_bars;
        n_result.peak_bars   = n_peak;
        n_result.peak_shown  = shown;
        n_result.marker_slot = slot[SlotW-1:0];
        n_result.shown_value = i_level.value;
        n_result.redraw      = i_level.value_changed | peak_moved;
        n_result.more_ticks  = !i_level.near_goal | shown;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak  <= '0;
            r_hold  <= '0;
            r_decay <= '0;
        end else if (i_load) begin
            r_peak  <= n_peak;
            r_hold  <= n_hold;
            r_decay <= n_decay;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

endmodule

@@ hw/rtl/bar_meter_smoothing_peak_hold_unit.sv @@
// Bar-graph level meter with smoothing and peak hold. Each input beat either
// loads a new target (opcode 0) or is a plain tick (opcode 1); both step the
// smoothed level once and give exactly one result beat. The block is a
// three-stage pipeline: the smoothing multiply, the bar scaling multiply and
// the peak hold logic each own one stage, so a beat can be taken in every
// cycle while the output is not stalled. Configuration writes take effect at
// once and are meant to be made only while no beat is in flight.
module bar_meter_smoothing_peak_hold_unit
    import bmsph_pkg::*;
#(
    parameter int unsigned BAR_COUNT  = BarCountDef,
    parameter int unsigned FULL_SCALE = FullScaleDef
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_opcode,
    input  logic [ValueW-1:0]   i_new_target,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [BarsW-1:0]    o_lit_bars,
    output logic [BarsW-1:0]    o_peak_bars,
    output logic                o_peak_shown,
    output logic [SlotW-1:0]    o_peak_slot,
    output logic [ValueW-1:0]   o_shown_value,
    output logic                o_redraw,
    output logic                o_more_ticks
);

    localparam int unsigned        BarsRecip = ((2 ** BarsShift) + FULL_SCALE - 1) / FULL_SCALE;
    localparam logic [BarsMulW-1:0] BarsMul  = BarsMulW'(BAR_COUNT * BarsRecip);
    localparam logic [BarsW-1:0]   BarsMax   = BarsW'(BAR_COUNT);

    logic [GainW-1:0]  r_rise_gain;
    logic [GainW-1:0]  r_fall_gain;
    logic [CountW-1:0] r_hold_ticks;
    logic [CountW-1:0] r_decay_ticks;

    logic              r_va;
    logic              r_vb;
    logic              r_vo;
    logic              en_a;
    logic              en_b;
    logic              en_o;
    logic              accept;
    logic              load_b;
    logic              load_o;

    t_level            level_a;
    t_level            r_level_b;
    logic [BarsW-1:0]  r_bars_b;
    logic [BarsW-1:0]  n_bars_b;
    logic [BarsProdW-1:0] bars_prod;
    logic [BarsQuotW-1:0] bars_quot;
    t_result           result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rise_gain   <= RiseGainReset;
            r_fall_gain   <= FallGainReset;
            r_hold_ticks  <= HoldTicksReset;
            r_decay_ticks <= DecayTicksReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RISE_GAIN:   r_rise_gain   <= i_cfg_data;
                CFG_FALL_GAIN:   r_fall_gain   <= i_cfg_data;
                CFG_HOLD_TICKS:  r_hold_ticks  <= i_cfg_data;
                CFG_DECAY_TICKS: r_decay_ticks <= i_cfg_data;
                default:         r_rise_gain   <= r_rise_gain;
            endcase
        end
    end

    // Each stage moves on when it is empty or the stage after it moves on,
    // so bubbles close up while the output is stalled.
    assign en_o    = !r_vo | i_ready;
    assign en_b    = !r_vb | en_o;
    assign en_a    = !r_va | en_b;
    assign o_ready = en_a;
    assign accept  = i_valid & en_a;
    assign load_b  = r_va & en_b;
    assign load_o  = r_vb & en_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (en_a) begin
                r_va <= i_valid;
            end
            if (en_b) begin
                r_vb <= r_va;
            end
            if (en_o) begin
                r_vo <= r_vb;
            end
        end
    end

    bmsph_smooth u_smooth (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (accept),
        .i_opcode     (i_opcode),
        .i_new_target (i_new_target),
        .i_rise_gain  (r_rise_gain),
        .i_fall_gain  (r_fall_gain),
        .o_level      (level_a)
    );

    always_comb begin
        bars_prod = BarsProdW'(level_a.value) * BarsProdW'(BarsMul);
        bars_quot = bars_prod[BarsProdW-1:BarsShift];
        if (bars_quot > BarsQuotW'(BAR_COUNT)) begin
            n_bars_b = BarsMax;
        end else begin
            n_bars_b = bars_quot[BarsW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_b) begin
            r_level_b <= level_a;
            r_bars_b  <= n_bars_b;
        end
    end

    bmsph_peak #(
        .BAR_COUNT (BAR_COUNT)
    ) u_peak (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (load_o),
        .i_level       (r_level_b),
        .i_bars        (r_bars_b),
        .i_hold_ticks  (r_hold_ticks),
        .i_decay_ticks (r_decay_ticks),
        .o_result      (result)
    );

    assign o_valid       = r_vo;
    assign o_lit_bars    = result.lit_bars;
    assign o_peak_bars   = result.peak_bars;
    assign o_peak_shown  = result.peak_shown;
    assign o_peak_slot   = result.marker_slot;
    assign o_shown_value = result.shown_value;
    assign o_redraw      = result.redraw;
    assign o_more_ticks  = result.more_ticks;

    a_lit_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_lit_bars <= BarsMax)
        else $error("lit bars exceed the bar count");

    a_peak_above: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_peak_shown |-> o_peak_bars > o_lit_bars)
        else $error("peak marker shown without being above the lit bars");

    a_slot_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_peak_shown |-> o_peak_slot == '0)
        else $error("peak slot set while the marker is hidden");

    a_more_ticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_peak_shown |-> o_more_ticks)
        else $error("meter reports settled while the peak is still up");

endmodule
